>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPLY(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/fcache_pkg.sv
`timescale 1ns / 1ps
package fcache_pkg;
    localparam int unsigned Sources = 16;
    localparam int unsigned Ways = 8;
    localparam int unsigned SrcW = $clog2(Sources);
    localparam int unsigned WayW = $clog2(Ways);
    localparam int unsigned SlotW = SrcW + WayW;
    localparam int unsigned Slots = Sources * Ways;
    localparam logic [15:0] DefaultFrameMs = 16'd33;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_SETDUR = 2'd2;
    localparam logic [1:0] KIND_DROP   = 2'd3;

    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_NEAR    = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  source;
        logic [31:0] time_ms;
        logic [11:0] width;
        logic [11:0] height;
        logic [15:0] picture;
        logic [15:0] frame_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] picture_out;
        logic        evicted;
    } t_out_word;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [11:0] width;
        logic [11:0] height;
        logic [15:0] picture;
        logic [31:0] use_stamp;
        logic [31:0] order;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [31:0]      dividend;
        logic [15:0]      divisor;
    } t_div_req;
endpackage

>>> rtl/frame_cache_nearest_lru_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Frame cache with nearest-time match and LRU replacement, 16 sources x 8 ways.
// Command channel: drive i_cmd with start high while busy is low; the word
// is taken at that edge. Kinds: lookup, store, set frame duration, drop source.
// Result channel: o_res is valid for exactly one cycle while o_res_valid is
// high; the receiver cannot stall it, and busy stays high through that cycle.
// Config channel: i_cfg_valid/o_cfg_ready writes the default frame duration;
// write only while idle. Reset value is 33.
// Steps: a lookup or store first divides the request time by the frame duration,
// then walks the source's 8 entries in the entry RAM, reading each in turn, with
// a bit-serial bucket divide for each valid entry of the requested size, then
// a write-back state that registers the result and the entry write.
// Set, drop and zero-size lookups skip these steps and register their result in S_OUT.
// One item at a time; the next word is taken no earlier than the edge after the
// result cycle. The single-port-read entry RAM and the shared divider set the rate.
// Reset clears valid bits, durations and use/insert counters at once; no clearing pass.
module frame_cache_nearest_lru_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  fcache_pkg::t_in_word  i_cmd,
    output logic                  o_res_valid,
    output fcache_pkg::t_out_word o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);
    localparam int unsigned SrcW = fcache_pkg::SrcW;
    localparam int unsigned WayW = fcache_pkg::WayW;

    typedef enum logic [3:0] {
        S_IDLE, S_QDIV, S_QWAIT, S_RD, S_RWAIT, S_EDIV, S_EWAIT, S_DONE, S_WB, S_OUT
    } t_state;

    t_state r_state;
    fcache_pkg::t_in_word r_cmd;
    logic [15:0] r_deflt;
    logic [15:0] r_dur [fcache_pkg::Sources];
    logic [fcache_pkg::Slots-1:0] r_valid;
    logic [31:0] r_use_cnt, r_ins_cnt;
    logic [WayW:0] r_way;
    logic [31:0] r_qbucket;
    fcache_pkg::t_entry r_ent;

    logic r_hit_f; logic [WayW-1:0] r_hit; logic [31:0] r_hit_age;
    logic r_nr_f; logic [31:0] r_nr_d, r_nr_age;
    logic [15:0] r_nr_pic, r_hit_pic;
    logic r_fr_f; logic [WayW-1:0] r_fr;
    logic r_lru_f; logic [WayW-1:0] r_lru; logic [31:0] r_lru_age;
    fcache_pkg::t_entry r_hit_ent;

    logic r_res_v; fcache_pkg::t_out_word r_res;
    logic r_we; logic [fcache_pkg::SlotW-1:0] r_waddr; fcache_pkg::t_entry r_wdata;

    fcache_pkg::t_out_word n_res;
    logic n_we;
    logic [fcache_pkg::SlotW-1:0] n_waddr;
    fcache_pkg::t_entry n_wdata;
    logic [WayW-1:0] w_ins_way;

    fcache_pkg::t_div_req w_dreq;
    logic w_ddone; logic [31:0] w_dq;
    fcache_pkg::t_entry w_rdata;
    logic [fcache_pkg::SlotW-1:0] w_raddr;
    logic [15:0] w_d;
    logic [SrcW-1:0] w_src;
    logic [fcache_pkg::SlotW-1:0] w_slot;
    logic w_match;
    logic [31:0] w_iage, w_uage, w_dist;

    assign w_src = r_cmd.source;
    assign w_slot = {w_src, r_way[WayW-1:0]};
    assign w_raddr = w_slot;
    always_comb begin
        w_d = (r_dur[w_src] != 16'd0) ? r_dur[w_src] : r_deflt;
        if (w_d == 16'd0) w_d = 16'd1;
    end
    assign w_match = r_valid[w_slot] && w_rdata.width == r_cmd.width
                     && w_rdata.height == r_cmd.height;
    assign w_iage = r_ins_cnt - r_ent.order;
    assign w_uage = r_use_cnt - r_ent.use_stamp;
    assign w_dist = (r_ent.time_ms > r_cmd.time_ms) ? r_ent.time_ms - r_cmd.time_ms
                                                    : r_cmd.time_ms - r_ent.time_ms;

    always_comb begin
        w_dreq.start = 1'b0;
        w_dreq.dividend = r_cmd.time_ms;
        w_dreq.divisor = w_d;
        if (r_state == S_QDIV) w_dreq.start = 1'b1;
        if (r_state == S_EDIV) begin
            w_dreq.start = 1'b1;
            w_dreq.dividend = r_ent.time_ms;
        end
    end

    always_comb begin
        w_ins_way = r_fr_f ? r_fr : r_lru;
        n_res = '{status: fcache_pkg::ST_DONE, picture_out: 16'd0, evicted: 1'b0};
        n_we = 1'b0;
        n_waddr = {w_src, r_hit};
        n_wdata = r_hit_ent;
        if (r_cmd.kind == fcache_pkg::KIND_LOOKUP) begin
            if (r_hit_f) begin
                n_res.status = fcache_pkg::ST_HIT;
                n_res.picture_out = r_hit_pic;
                n_we = 1'b1;
                n_wdata.use_stamp = r_use_cnt + 32'd1;
            end else if (r_nr_f) begin
                n_res.status = fcache_pkg::ST_NEAR;
                n_res.picture_out = r_nr_pic;
            end else begin
                n_res.status = fcache_pkg::ST_NONE;
            end
        end else begin
            n_we = 1'b1;
            if (r_hit_f) begin
                n_wdata.time_ms = r_cmd.time_ms;
                n_wdata.picture = r_cmd.picture;
                n_wdata.use_stamp = r_use_cnt + 32'd1;
            end else begin
                n_waddr = {w_src, w_ins_way};
                n_res.evicted = !r_fr_f;
                n_wdata = '{time_ms: r_cmd.time_ms, width: r_cmd.width,
                            height: r_cmd.height, picture: r_cmd.picture,
                            use_stamp: r_use_cnt + 32'd1, order: r_ins_cnt + 32'd1};
            end
        end
    end

    fcache_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
                      .o_done(w_ddone), .o_quot(w_dq));
    fcache_ram u_ram (.i_clk(i_clk), .i_we(r_we), .i_waddr(r_waddr), .i_wdata(r_wdata),
                      .i_raddr(w_raddr), .o_rdata(w_rdata));

    logic r_slot_ok;
    logic [SrcW-1:0] w_ws;
    assign w_ws = i_cmd.source;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_deflt <= fcache_pkg::DefaultFrameMs;
            for (int i = 0; i < fcache_pkg::Sources; i++) r_dur[i] <= 16'd0;
            r_valid <= '0;
            r_use_cnt <= '0;
            r_ins_cnt <= '0;
            r_res_v <= 1'b0;
            r_we <= 1'b0;
        end else begin
            r_res_v <= (r_state == S_WB) || (r_state == S_OUT);
            r_we <= (r_state == S_WB) && n_we;
            if (i_cfg_valid) r_deflt <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (start && !r_res_v) begin
                        r_cmd <= i_cmd;
                        r_way <= '0;
                        r_hit_f <= 1'b0; r_nr_f <= 1'b0; r_fr_f <= 1'b0; r_lru_f <= 1'b0;
                        r_slot_ok <= 1'b1;
                        case (i_cmd.kind)
                            fcache_pkg::KIND_SETDUR: begin
                                r_dur[w_ws] <= (i_cmd.frame_ms == 16'd0) ? 16'd1
                                                                         : i_cmd.frame_ms;
                                r_state <= S_OUT;
                            end
                            fcache_pkg::KIND_DROP: begin
                                r_dur[w_ws] <= 16'd0;
                                for (int s = 0; s < fcache_pkg::Ways; s++)
                                    r_valid[{w_ws, s[WayW-1:0]}] <= 1'b0;
                                r_state <= S_OUT;
                            end
                            fcache_pkg::KIND_LOOKUP: begin
                                if (i_cmd.width == 12'd0 || i_cmd.height == 12'd0)
                                    r_state <= S_OUT;
                                else
                                    r_state <= S_QDIV;
                            end
                            default: r_state <= S_QDIV;
                        endcase
                    end
                end
                S_QDIV: r_state <= S_QWAIT;
                S_QWAIT: if (w_ddone) begin
                    r_qbucket <= w_dq;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_RWAIT;
                S_RWAIT: begin
                    r_ent <= w_rdata;
                    if (!r_valid[w_slot]) begin
                        if (!r_fr_f) begin
                            r_fr_f <= 1'b1;
                            r_fr <= r_way[WayW-1:0];
                        end
                        r_state <= S_DONE;
                    end else if (w_match) begin
                        r_state <= S_EDIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                    r_slot_ok <= r_valid[w_slot];
                end
                S_EDIV: r_state <= S_EWAIT;
                S_EWAIT: if (w_ddone) begin
                    if (w_dq == r_qbucket && (!r_hit_f || w_iage > r_hit_age)) begin
                        r_hit_f <= 1'b1;
                        r_hit <= r_way[WayW-1:0];
                        r_hit_age <= w_iage;
                        r_hit_pic <= r_ent.picture;
                        r_hit_ent <= r_ent;
                    end
                    if (!r_nr_f || w_dist < r_nr_d ||
                        (w_dist == r_nr_d && w_iage > r_nr_age)) begin
                        r_nr_f <= 1'b1;
                        r_nr_d <= w_dist;
                        r_nr_age <= w_iage;
                        r_nr_pic <= r_ent.picture;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_slot_ok && (!r_lru_f || w_uage > r_lru_age)) begin
                        r_lru_f <= 1'b1;
                        r_lru <= r_way[WayW-1:0];
                        r_lru_age <= w_uage;
                    end
                    if (r_way == (WayW+1)'(fcache_pkg::Ways - 1)) r_state <= S_WB;
                    else r_state <= S_RD;
                    r_way <= r_way + 1'b1;
                end
                S_WB: begin
                    r_res <= n_res;
                    r_waddr <= n_waddr;
                    r_wdata <= n_wdata;
                    if (r_cmd.kind != fcache_pkg::KIND_LOOKUP || r_hit_f)
                        r_use_cnt <= r_use_cnt + 32'd1;
                    if (r_cmd.kind != fcache_pkg::KIND_LOOKUP && !r_hit_f) begin
                        r_ins_cnt <= r_ins_cnt + 32'd1;
                        r_valid[{w_src, w_ins_way}] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    r_res <= '{status: (r_cmd.kind == fcache_pkg::KIND_LOOKUP) ?
                                       fcache_pkg::ST_NONE : fcache_pkg::ST_DONE,
                               picture_out: 16'd0, evicted: 1'b0};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE) || r_res_v;
    assign o_res_valid = r_res_v;
    assign o_res = r_res;
    assign o_cfg_ready = 1'b1;

    `AST_NEXT(a_res_one, i_clk, i_rst_n, o_res_valid, !o_res_valid)
    `AST_IMPLY(a_busy_res, i_clk, i_rst_n, o_res_valid, busy)
    `AST_IMPLY(a_evict_store, i_clk, i_rst_n, o_res_valid && o_res.evicted,
               o_res.status == fcache_pkg::ST_DONE)
endmodule

>>> rtl/fcache_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcache_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcache_pkg::t_div_req  i_req,
    output logic                  o_done,
    output logic [31:0]           o_quot
);
    logic [31:0] r_quot, n_quot;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_sh;

    always_comb begin
        w_sh = {r_rem[15:0], r_quot[31]};
        n_quot = {r_quot[30:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_dvs}) begin
            n_rem = w_sh - {1'b0, r_dvs};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 6'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd32;
                r_quot <= i_req.dividend;
                r_rem <= '0;
                r_dvs <= i_req.divisor;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `AST_NEXT(a_div_done, i_clk, i_rst_n, r_busy && r_cnt == 6'd1 && !i_req.start, o_done)
    `AST_IMPLY(a_div_cnt, i_clk, i_rst_n, r_busy, r_cnt != 6'd0)
    `AST_NEXT(a_div_idle, i_clk, i_rst_n, !r_busy && !i_req.start, !o_done)
endmodule

>>> rtl/fcache_ram.sv
`timescale 1ns / 1ps
module fcache_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [fcache_pkg::SlotW-1:0]  i_waddr,
    input  fcache_pkg::t_entry            i_wdata,
    input  logic [fcache_pkg::SlotW-1:0]  i_raddr,
    output fcache_pkg::t_entry            o_rdata
);
    fcache_pkg::t_entry r_mem [fcache_pkg::Slots];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> verif/tb_frame_cache_nearest_lru_unit.sv
`timescale 1ns / 1ps
module tb_frame_cache_nearest_lru_unit;
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    fcache_pkg::t_in_word  i_cmd = '0;
    logic                  o_res_valid;
    fcache_pkg::t_out_word o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [15:0]           i_cfg_data = 16'd0;

    frame_cache_nearest_lru_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // cache shadow
    logic        sh_valid [fcache_pkg::Slots];
    logic [31:0] sh_time [fcache_pkg::Slots];
    logic [11:0] sh_width [fcache_pkg::Slots];
    logic [11:0] sh_height [fcache_pkg::Slots];
    logic [15:0] sh_pic [fcache_pkg::Slots];
    logic [31:0] sh_use [fcache_pkg::Slots];
    logic [31:0] sh_order [fcache_pkg::Slots];
    logic [15:0] sh_dur [fcache_pkg::Sources];
    logic [31:0] use_ctr;
    logic [31:0] ins_ctr;
    logic [15:0] dflt_ms;

    fcache_pkg::t_in_word  cmd_q [$];
    fcache_pkg::t_out_word res_q [$];
    int        errors = 0;
    int        burst_left = 0;
    int        gap_left = 0;

    function automatic logic [31:0] dur_of(int src);
        logic [31:0] d;
        d = (sh_dur[src] != 16'd0) ? 32'(sh_dur[src]) : 32'(dflt_ms);
        return (d == 32'd0) ? 32'd1 : d;
    endfunction

    function automatic int bucket_match(fcache_pkg::t_in_word c);
        int          best;
        int          i;
        logic [31:0] d;
        logic [31:0] age;
        logic [31:0] best_age;
        best = -1;
        best_age = 32'd0;
        d = dur_of(c.source);
        for (int s = 0; s < fcache_pkg::Ways; s++) begin
            i = c.source * fcache_pkg::Ways + s;
            if (!sh_valid[i] || sh_width[i] != c.width || sh_height[i] != c.height)
                continue;
            if (sh_time[i] / d != c.time_ms / d)
                continue;
            age = ins_ctr - sh_order[i];
            if (best < 0 || age > best_age) begin
                best = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic fcache_pkg::t_out_word predict_result(fcache_pkg::t_in_word c);
        fcache_pkg::t_out_word r;
        int          hit;
        int          near;
        int          slot;
        int          lru;
        int          i;
        logic [31:0] nd;
        logic [31:0] na;
        logic [31:0] dd;
        logic [31:0] age;
        logic [31:0] lru_age;
        r = '{status: fcache_pkg::ST_DONE, picture_out: 16'd0, evicted: 1'b0};
        case (c.kind)
            fcache_pkg::KIND_LOOKUP: begin
                r.status = fcache_pkg::ST_NONE;
                if (c.width != 12'd0 && c.height != 12'd0) begin
                    hit = bucket_match(c);
                    if (hit >= 0) begin
                        use_ctr = use_ctr + 32'd1;
                        sh_use[hit] = use_ctr;
                        r.status = fcache_pkg::ST_HIT;
                        r.picture_out = sh_pic[hit];
                    end else begin
                        near = -1;
                        nd = 32'd0;
                        na = 32'd0;
                        for (int s = 0; s < fcache_pkg::Ways; s++) begin
                            i = c.source * fcache_pkg::Ways + s;
                            if (!sh_valid[i] || sh_width[i] != c.width ||
                                sh_height[i] != c.height)
                                continue;
                            dd = (sh_time[i] > c.time_ms) ? sh_time[i] - c.time_ms
                                                          : c.time_ms - sh_time[i];
                            age = ins_ctr - sh_order[i];
                            if (near < 0 || dd < nd || (dd == nd && age > na)) begin
                                near = i;
                                nd = dd;
                                na = age;
                            end
                        end
                        if (near >= 0) begin
                            r.status = fcache_pkg::ST_NEAR;
                            r.picture_out = sh_pic[near];
                        end
                    end
                end
            end
            fcache_pkg::KIND_STORE: begin
                hit = bucket_match(c);
                use_ctr = use_ctr + 32'd1;
                if (hit >= 0) begin
                    sh_pic[hit] = c.picture;
                    sh_time[hit] = c.time_ms;
                    sh_use[hit] = use_ctr;
                end else begin
                    slot = -1;
                    lru = -1;
                    lru_age = 32'd0;
                    for (int s = 0; s < fcache_pkg::Ways; s++) begin
                        i = c.source * fcache_pkg::Ways + s;
                        if (!sh_valid[i]) begin
                            if (slot < 0)
                                slot = i;
                            continue;
                        end
                        age = (use_ctr - 32'd1) - sh_use[i];
                        if (lru < 0 || age > lru_age) begin
                            lru = i;
                            lru_age = age;
                        end
                    end
                    if (slot < 0) begin
                        slot = lru;
                        r.evicted = 1'b1;
                    end
                    ins_ctr = ins_ctr + 32'd1;
                    sh_valid[slot] = 1'b1;
                    sh_time[slot] = c.time_ms;
                    sh_width[slot] = c.width;
                    sh_height[slot] = c.height;
                    sh_pic[slot] = c.picture;
                    sh_use[slot] = use_ctr;
                    sh_order[slot] = ins_ctr;
                end
            end
            fcache_pkg::KIND_SETDUR:
                sh_dur[c.source] = (c.frame_ms == 16'd0) ? 16'd1 : c.frame_ms;
            default: begin
                for (int s = 0; s < fcache_pkg::Ways; s++)
                    sh_valid[c.source * fcache_pkg::Ways + s] = 1'b0;
                sh_dur[c.source] = 16'd0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic enqueue_cmd(fcache_pkg::t_in_word c);
        cmd_q = {cmd_q, c};
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                res_q = {res_q, predict_result(i_cmd)};
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    start <= 1'b1;
                    i_cmd <= cmd_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        fcache_pkg::t_out_word want;
        if (i_rst_n && o_res_valid) begin
            if (res_q.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_res), 32'd0);
            end else begin
                want = res_q.pop_front();
                if (o_res.status != want.status)
                    report_mismatch("status", 32'(o_res.status), 32'(want.status));
                if (o_res.picture_out != want.picture_out)
                    report_mismatch("picture_out", 32'(o_res.picture_out),
                                    32'(want.picture_out));
                if (o_res.evicted != want.evicted)
                    report_mismatch("evicted", 32'(o_res.evicted), 32'(want.evicted));
            end
        end
    end

    function automatic fcache_pkg::t_in_word mk(logic [1:0] k, logic [3:0] src,
                                                logic [31:0] t, logic [11:0] w,
                                                logic [11:0] h, logic [15:0] p,
                                                logic [15:0] f);
        fcache_pkg::t_in_word c;
        c.kind = k;
        c.source = src;
        c.time_ms = t;
        c.width = w;
        c.height = h;
        c.picture = p;
        c.frame_ms = f;
        return c;
    endfunction

    function automatic fcache_pkg::t_in_word rand_word();
        fcache_pkg::t_in_word c;
        int          sel;
        logic [11:0] w;
        logic [11:0] h;
        logic [31:0] t;
        logic [3:0]  src;
        sel = $urandom_range(0, 99);
        src = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: begin w = 12'd4095; h = 12'd4095; end
            1: begin w = 12'($urandom); h = 12'($urandom); end
            2, 3: begin w = 12'd1; h = 12'd1; end
            default: begin w = 12'd64; h = 12'd36; end
        endcase
        case ($urandom_range(0, 9))
            0: t = $urandom;
            1: t = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: t = 32'(src) * 32'd1000 + $urandom_range(0, 400);
        endcase
        c = mk(fcache_pkg::KIND_LOOKUP, src, t, w, h, 16'($urandom), 16'($urandom));
        if (sel < 45)
            c.kind = fcache_pkg::KIND_LOOKUP;
        else if (sel < 87)
            c.kind = fcache_pkg::KIND_STORE;
        else if (sel < 94)
            c.kind = fcache_pkg::KIND_SETDUR;
        else
            c.kind = fcache_pkg::KIND_DROP;
        if (c.kind == fcache_pkg::KIND_SETDUR && $urandom_range(0, 1) == 1)
            c.frame_ms = 16'($urandom_range(0, 100));
        return c;
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() > 0 || start || res_q.size() > 0 || busy)
            @(negedge i_clk);
    endtask

    task automatic write_default(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        dflt_ms = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] phase_ms [4];
        for (int i = 0; i < fcache_pkg::Slots; i++)
            sh_valid[i] = 1'b0;
        for (int i = 0; i < fcache_pkg::Sources; i++)
            sh_dur[i] = 16'd0;
        use_ctr = 32'd0;
        ins_ctr = 32'd0;
        dflt_ms = fcache_pkg::DefaultFrameMs;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd0, 32'd0, 12'd64, 12'd36, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_STORE, 4'd0, 32'd0, 12'd4095, 12'd4095,
                       16'hFFFF, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_STORE, 4'd0, 32'hFFFF_FFFF, 12'd4095, 12'd4095,
                       16'h0001, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd0, 32'd10, 12'd4095, 12'd4095,
                       16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd0, 32'h8000_0000, 12'd4095, 12'd4095,
                       16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd0, 32'd5, 12'd0, 12'd4095, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd0, 32'd5, 12'd4095, 12'd0, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_SETDUR, 4'd1, 32'd0, 12'd0, 12'd0, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_STORE, 4'd1, 32'd100, 12'd1, 12'd1, 16'h00A1, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_STORE, 4'd1, 32'd300, 12'd1, 12'd1, 16'h00A2, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd1, 32'd200, 12'd1, 12'd1, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_SETDUR, 4'd1, 32'd0, 12'd0, 12'd0, 16'd0, 16'hFFFF));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd1, 32'd200, 12'd1, 12'd1, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_STORE, 4'd1, 32'd250, 12'd1, 12'd1, 16'h00A3, 16'd0));
        for (int i = 0; i < 9; i++)
            enqueue_cmd(mk(fcache_pkg::KIND_STORE, 4'd15, 32'(i) * 32'd100, 12'd64, 12'd36,
                           16'(16'hB0 + i), 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_DROP, 4'd15, 32'd0, 12'd0, 12'd0, 16'd0, 16'd0));
        enqueue_cmd(mk(fcache_pkg::KIND_LOOKUP, 4'd15, 32'd100, 12'd64, 12'd36,
                       16'd0, 16'd0));

        phase_ms[0] = 16'd1;
        phase_ms[1] = 16'hFFFF;
        phase_ms[2] = 16'd0;
        phase_ms[3] = 16'($urandom_range(2, 200));
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_default(phase_ms[ph]);
            for (int n = 0; n < 310; n++)
                enqueue_cmd(rand_word());
        end

        wait_idle();
        repeat (400) @(posedge i_clk);
        if (errors == 0 && res_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
